/* src/bbart_pkg.sv */
// shared types, codes and state encodings for the box accumulate / ray test block
// no dependencies
package bbart_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TW     = 31;
  localparam int unsigned QuotW  = 49;   // |(b - o) * 65536| < 2^49
  localparam int unsigned DivW   = 50;   // signed dividend width

  typedef enum logic [1:0] {
    OP_EXPAND = 2'd0,
    OP_POINT  = 2'd1,
    OP_RAY    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic        inside_res;
    logic        hit;
    logic [30:0] t_near;
    logic [30:0] t_far;
    logic [1:0]  long_axis;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;       // capture input beat
    logic       exec;       // run expand / point test / ray setup
    logic       div_start;  // start one division
    logic       div_take;   // fold finished quotient into interval
    logic [1:0] axis;
    logic       far_sel;    // 0 min bound, 1 max bound
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ray;
    logic ray_dead;   // interval already empty / miss
    logic dir_zero;   // current axis direction is zero
    logic div_done;
  } sts_t;

endpackage

/* src/bbart_div.sv */
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on bbart_pkg
module bbart_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [bbart_pkg::DivW-1:0]   num_i,
  input  logic signed [31:0]                  den_i,
  output logic                                done_o,
  output logic signed [bbart_pkg::DivW-1:0]   quo_o
);

  localparam int unsigned CntW = $clog2(bbart_pkg::DivW + 1);

  logic [bbart_pkg::DivW-1:0] rem_q, rem_d;
  logic [bbart_pkg::DivW-1:0] quo_q, quo_d;
  logic [31:0]                den_q, den_d;
  logic                       neg_q, neg_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [bbart_pkg::DivW-1:0] rem_sh;
  logic [bbart_pkg::DivW-1:0] num_abs;

  always_comb begin
    num_abs = num_i[bbart_pkg::DivW-1] ? bbart_pkg::DivW'(-num_i) : num_i;
    rem_sh  = {rem_q[bbart_pkg::DivW-2:0], quo_q[bbart_pkg::DivW-1]};
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_abs;
      den_d  = den_i[31] ? 32'(-den_i) : den_i;
      neg_d  = num_i[bbart_pkg::DivW-1] ^ den_i[31];
      cnt_d  = CntW'(bbart_pkg::DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= bbart_pkg::DivW'(den_q)) begin
        rem_d = rem_sh - bbart_pkg::DivW'(den_q);
        quo_d = {quo_q[bbart_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[bbart_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? bbart_pkg::DivW'(-quo_q) : quo_q;

endmodule

/* src/bbart_datapath.sv */
// box registers, compares, ray interval and shared divider
// depends on bbart_pkg, bbart_div
module bbart_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbart_pkg::in_t    in_i,
  input  bbart_pkg::cmd_t   cmd_i,
  output bbart_pkg::sts_t   sts_o,
  output bbart_pkg::out_t   res_o
);

  logic signed [31:0] min_q [3];
  logic signed [31:0] max_q [3];
  bbart_pkg::in_t     item_q;
  logic               inside_q;
  logic               dead_q;
  logic               ray_q;
  logic signed [32:0] lo_q, hi_q;   // running interval
  logic signed [32:0] tn_q;         // min-bound quotient of current axis

  logic signed [31:0] pt   [3];
  logic signed [31:0] dr   [3];
  logic signed [31:0] bnd, org, den;
  logic signed [32:0] diff;
  logic signed [bbart_pkg::DivW-1:0] num;
  logic signed [bbart_pkg::DivW-1:0] quo;
  logic signed [32:0] qsat, tn, tf, lo_n, hi_n;
  logic               div_done;
  logic signed [32:0] ex [3];
  logic [1:0]         major;

  assign pt[0] = item_q.point_x;
  assign pt[1] = item_q.point_y;
  assign pt[2] = item_q.point_z;
  assign dr[0] = item_q.dir_x;
  assign dr[1] = item_q.dir_y;
  assign dr[2] = item_q.dir_z;

  always_comb begin
    bnd  = cmd_i.far_sel ? max_q[cmd_i.axis] : min_q[cmd_i.axis];
    org  = pt[cmd_i.axis];
    den  = dr[cmd_i.axis];
    diff = 33'(bnd) - 33'(org);
    num  = bbart_pkg::DivW'(signed'({diff, 16'h0000}));
  end

  bbart_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // saturate quotient to signed 32 bits
  always_comb begin
    if (quo > bbart_pkg::DivW'(signed'(33'sh07FFFFFFF)))
      qsat = 33'sh07FFFFFFF;
    else if (quo < -bbart_pkg::DivW'(signed'(33'sh080000000)))
      qsat = -33'sh080000000;
    else
      qsat = quo[32:0];
    tn   = (tn_q > qsat) ? qsat : tn_q;
    tf   = (tn_q > qsat) ? tn_q : qsat;
    lo_n = (tn > lo_q) ? tn : lo_q;
    hi_n = (tf < hi_q) ? tf : hi_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = 33'(max_q[i]) - 33'(min_q[i]);
    end
    if (ex[0] > ex[1] && ex[0] > ex[2]) major = bbart_pkg::AXIS_X;
    else if (ex[1] > ex[2])            major = bbart_pkg::AXIS_Y;
    else                               major = bbart_pkg::AXIS_Z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= 32'sh7FFFFFFF;
        max_q[i] <= 32'sh80000000;
      end
      dead_q   <= 1'b0;
      ray_q    <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        ray_q    <= (item_q.operation == bbart_pkg::OP_RAY);
        inside_q <= 1'b0;
        dead_q   <= 1'b0;
        case (item_q.operation)
          bbart_pkg::OP_EXPAND: begin
            for (int i = 0; i < 3; i++) begin
              if (pt[i] > max_q[i]) max_q[i] <= pt[i];
              if (pt[i] < min_q[i]) min_q[i] <= pt[i];
            end
          end
          bbart_pkg::OP_POINT: begin
            inside_q <= pt[0] <= max_q[0] && pt[1] <= max_q[1] && pt[2] <= max_q[2]
                     && pt[0] >= min_q[0] && pt[1] >= min_q[1] && pt[2] >= min_q[2];
          end
          bbart_pkg::OP_RAY: begin
            dead_q <= !(min_q[0] <= max_q[0] && min_q[1] <= max_q[1]
                        && min_q[2] <= max_q[2]);
          end
          default: begin
          end
        endcase
      end else if (cmd_i.div_start && den == 32'sd0) begin
        // zero direction: miss only when origin is outside the slab
        if (org < min_q[cmd_i.axis] || org > max_q[cmd_i.axis]) dead_q <= 1'b1;
      end else if (cmd_i.div_take && cmd_i.far_sel) begin
        if (lo_n > hi_n) dead_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.exec) begin
      lo_q <= '0;
      hi_q <= 33'sh07FFFFFFF;
    end
    if (cmd_i.div_take) begin
      if (!cmd_i.far_sel) begin
        tn_q <= qsat;
      end else begin
        lo_q <= lo_n;
        hi_q <= hi_n;
      end
    end
  end

  assign sts_o.is_ray   = ray_q;
  assign sts_o.ray_dead = dead_q;
  assign sts_o.dir_zero = (den == 32'sd0);
  assign sts_o.div_done = div_done;

  assign res_o.inside_res = inside_q;
  assign res_o.hit        = ray_q && !dead_q;
  assign res_o.t_near     = (ray_q && !dead_q) ? lo_q[30:0] : '0;
  assign res_o.t_far      = (ray_q && !dead_q) ? hi_q[30:0] : '0;
  assign res_o.long_axis  = major;

endmodule

/* src/bbart_ctrl.sv */
// sequencing state machine: capture, execute, per-axis division steps, output
// depends on bbart_pkg
module bbart_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bbart_pkg::sts_t  sts_i,
  output bbart_pkg::cmd_t  cmd_o
);

  bbart_pkg::state_e state_q, state_d;
  logic [1:0]        axis_q, axis_d;
  logic              far_q, far_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbart_pkg::ST_IDLE;
      axis_q  <= '0;
      far_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      far_q   <= far_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    far_d        = far_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.axis   = axis_q;
    cmd_o.far_sel = far_q;
    case (state_q)
      bbart_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bbart_pkg::ST_EXEC;
        end
      end
      bbart_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        axis_d     = bbart_pkg::AXIS_X;
        far_d      = 1'b0;
        state_d    = bbart_pkg::ST_DIV_START;
      end
      bbart_pkg::ST_DIV_START: begin
        if (!sts_i.is_ray || sts_i.ray_dead) begin
          state_d = bbart_pkg::ST_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          if (sts_i.dir_zero) begin
            // axis adds no limit; skip both bounds
            far_d = 1'b0;
            if (axis_q == bbart_pkg::AXIS_Z) state_d = bbart_pkg::ST_OUT;
            else axis_d = axis_q + 2'd1;
          end else begin
            state_d = bbart_pkg::ST_DIV_WAIT;
          end
        end
      end
      bbart_pkg::ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = bbart_pkg::ST_DIV_START;
          if (!far_q) begin
            far_d = 1'b1;
          end else begin
            far_d = 1'b0;
            if (axis_q == bbart_pkg::AXIS_Z) state_d = bbart_pkg::ST_OUT;
            else axis_d = axis_q + 2'd1;
          end
        end
      end
      bbart_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = bbart_pkg::ST_IDLE;
      end
      default: state_d = bbart_pkg::ST_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_take_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_take |-> state_q == bbart_pkg::ST_DIV_WAIT) else $error("stray take");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");

endmodule

/* src/bounding_box_accumulate_ray_test.sv */
// top level: box accumulate, point containment and ray slab test
// depends on bbart_pkg, bbart_ctrl, bbart_datapath, bbart_div

// One item in, one result out, strictly one at a time. An expand, a point
// test or an unused code passes from input beat to result through capture,
// execute, dispatch and present. A ray test runs up to six signed divisions
// through one shared bit-serial divider of 50 steps each; an axis with zero
// direction waits on no division, and an early miss ends the item at once.
// The result beat is held until taken, and the next input beat is taken the
// cycle after. The box resets empty (min most positive, max most negative);
// results of the ray test are unsigned Q15.16 with saturation.
module bounding_box_accumulate_ray_test (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bbart_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bbart_pkg::out_t out_data_o
);

  bbart_pkg::cmd_t cmd;
  bbart_pkg::sts_t sts;

  // sequencer
  bbart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // box state, compares and divider
  bbart_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_data_o)
  );

endmodule
